>>> hdl/svhd_pkg.sv
// Shared constants, types and register indexes of the VIS header detector.
`default_nettype none

package svhd_pkg;

    localparam int unsigned SAMPLES_PER_BIT_DEF = 6;
    localparam int unsigned FRAME_BITS          = 22;

    localparam int unsigned FREQ_W   = 16;
    localparam int unsigned MARGIN_W = 12;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned GAP_W    = 17;
    localparam int unsigned FIVE_W   = 19;
    localparam int unsigned SUM_W    = 20;
    localparam int unsigned QMAG_W   = 17;
    localparam int unsigned SHIFT_W  = 15;
    localparam int unsigned CODE_W   = 7;
    localparam int unsigned VIS_BITS = 8;

    localparam int unsigned LEADER_TAP_A = 4;
    localparam int unsigned LEADER_TAP_B = 6;
    localparam int unsigned LEADER_TAP_C = 8;
    localparam int unsigned LEADER_TAP_D = 10;
    localparam int unsigned START_TAP    = 12;
    localparam int unsigned FIRST_DATA_TAP = 13;
    localparam int unsigned STOP_TAP     = 21;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ_MARGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_TONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_TONE    = 2'd2;

    localparam logic [MARGIN_W-1:0] FREQ_MARGIN_RST = 12'd400;
    localparam logic [FREQ_W-1:0]   LEADER_TONE_RST = 16'd30400;
    localparam logic [FREQ_W-1:0]   BIT_TONE_RST    = 16'd19200;

    // ceil(2^22 / 5): exact quotient by five for magnitudes below 2^22
    localparam int unsigned RECIP_W     = 20;
    localparam int unsigned RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP_5 = 20'd838861;
    localparam int unsigned PROD_W = FIVE_W + RECIP_W;

    localparam logic [QMAG_W-1:0] SHIFT_POS_LIMIT = 17'd16383;
    localparam logic [QMAG_W-1:0] SHIFT_NEG_LIMIT = 17'd16384;

    typedef struct packed {
        logic [FREQ_W-1:0]                 f0;
        logic [FREQ_W-1:0]                 fa;
        logic [FREQ_W-1:0]                 fb;
        logic [FREQ_W-1:0]                 fc;
        logic [FREQ_W-1:0]                 fd;
        logic [FREQ_W-1:0]                 fstart;
        logic [FREQ_W-1:0]                 fstop;
        logic [VIS_BITS-1:0][FREQ_W-1:0]   data;
    } taps_t;

    typedef struct packed {
        logic                              hit;
        logic signed [SUM_W-1:0]           sum;
        logic [VIS_BITS-1:0][FIVE_W-1:0]   data5;
    } match_t;

    typedef struct packed {
        logic                  hit;
        logic [VIS_BITS-1:0]   word;
        logic                  neg;
        logic [QMAG_W-1:0]     qmag;
    } decide_t;

endpackage

`default_nettype wire

>>> hdl/svhd_delay_line.sv
// Sample delay line with fixed taps at the bit-period ages used by the detector.
`default_nettype none

module svhd_delay_line #(
    parameter int unsigned SAMPLES_PER_BIT = svhd_pkg::SAMPLES_PER_BIT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        shift_en,
    input  logic [svhd_pkg::FREQ_W-1:0] din,
    output svhd_pkg::taps_t             taps
);
    import svhd_pkg::*;

    localparam int unsigned DEPTH = SAMPLES_PER_BIT * FRAME_BITS;

    logic [FREQ_W-1:0] line_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                line_reg[i] <= '0;
            end
        end else if (shift_en) begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign taps.f0     = line_reg[DEPTH-1];
    assign taps.fa     = line_reg[DEPTH-1-LEADER_TAP_A*SAMPLES_PER_BIT];
    assign taps.fb     = line_reg[DEPTH-1-LEADER_TAP_B*SAMPLES_PER_BIT];
    assign taps.fc     = line_reg[DEPTH-1-LEADER_TAP_C*SAMPLES_PER_BIT];
    assign taps.fd     = line_reg[DEPTH-1-LEADER_TAP_D*SAMPLES_PER_BIT];
    assign taps.fstart = line_reg[DEPTH-1-START_TAP*SAMPLES_PER_BIT];
    assign taps.fstop  = line_reg[DEPTH-1-STOP_TAP*SAMPLES_PER_BIT];

    for (genvar k = 0; k < VIS_BITS; k++) begin : g_data
        assign taps.data[k] = line_reg[DEPTH-1-(FIRST_DATA_TAP+k)*SAMPLES_PER_BIT];
    end

endmodule

`default_nettype wire

>>> hdl/svhd_match.sv
// First stage: leader and start/stop tone tests, offset sum and scaled data taps.
`default_nettype none

module svhd_match (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               in_valid,
    input  svhd_pkg::taps_t                    taps,
    input  logic [svhd_pkg::MARGIN_W-1:0]      margin,
    input  logic signed [svhd_pkg::GAP_W-1:0]  gap,
    input  logic [svhd_pkg::FIVE_W-1:0]        five_leader,
    output logic                               out_valid,
    output svhd_pkg::match_t                   out
);
    import svhd_pkg::*;

    localparam int unsigned D_W = GAP_W + 1;

    logic signed [GAP_W-1:0] f0_s;
    logic signed [GAP_W-1:0] da;
    logic signed [GAP_W-1:0] db;
    logic signed [GAP_W-1:0] dc;
    logic signed [GAP_W-1:0] dd;
    logic signed [D_W-1:0]   dstart;
    logic signed [D_W-1:0]   dstop;
    logic [FIVE_W-1:0]       tone_sum;
    match_t                  out_next;
    logic                    out_valid_reg;
    match_t                  out_reg;

    function automatic logic in_band(input logic signed [D_W-1:0] x,
                                     input logic [MARGIN_W-1:0] m);
        logic signed [D_W-1:0] ms;
        ms = $signed({{(D_W-MARGIN_W){1'b0}}, m});
        return (x < ms) && (x > -ms);
    endfunction

    always_comb begin
        f0_s   = $signed({1'b0, taps.f0});
        da     = $signed({1'b0, taps.fa}) - f0_s;
        db     = $signed({1'b0, taps.fb}) - f0_s;
        dc     = $signed({1'b0, taps.fc}) - f0_s;
        dd     = $signed({1'b0, taps.fd}) - f0_s;
        dstart = $signed({{1{gap[GAP_W-1]}}, gap})
               + $signed({2'b00, taps.fstart}) - $signed({2'b00, taps.f0});
        dstop  = $signed({{1{gap[GAP_W-1]}}, gap})
               + $signed({2'b00, taps.fstop}) - $signed({2'b00, taps.f0});

        tone_sum = {3'b000, taps.f0} + {3'b000, taps.fa} + {3'b000, taps.fb}
                 + {3'b000, taps.fc} + {3'b000, taps.fd};

        out_next.hit = in_band({da[GAP_W-1], da}, margin)
                    && in_band({db[GAP_W-1], db}, margin)
                    && in_band({dc[GAP_W-1], dc}, margin)
                    && in_band({dd[GAP_W-1], dd}, margin)
                    && in_band(dstart, margin)
                    && in_band(dstop, margin);
        out_next.sum = $signed({1'b0, tone_sum}) - $signed({1'b0, five_leader});
        for (int k = 0; k < VIS_BITS; k++) begin
            out_next.data5[k] = {1'b0, taps.data[k], 2'b00} + {3'b000, taps.data[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

`default_nettype wire

>>> hdl/svhd_decide.sv
// Second stage: VIS bit decisions and offset magnitude divided by five.
`default_nettype none

module svhd_decide (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  svhd_pkg::match_t              in,
    input  logic [svhd_pkg::FIVE_W-1:0]   five_bit,
    output logic                          out_valid,
    output svhd_pkg::decide_t             out
);
    import svhd_pkg::*;

    localparam int unsigned DIFF_W = SUM_W + 1;

    logic signed [DIFF_W-1:0] diff [VIS_BITS];
    logic [SUM_W-1:0]         sum_neg;
    logic [FIVE_W-1:0]        sum_mag;
    logic [PROD_W-1:0]        prod;
    decide_t                  out_next;
    logic                     out_valid_reg;
    decide_t                  out_reg;

    always_comb begin
        for (int k = 0; k < VIS_BITS; k++) begin
            diff[k] = $signed({2'b00, in.data5[k]}) - $signed({in.sum[SUM_W-1], in.sum});
            out_next.word[k] = in.hit && (diff[k] < $signed({2'b00, five_bit}));
        end
        sum_neg      = 20'(-in.sum);
        sum_mag      = in.sum[SUM_W-1] ? sum_neg[FIVE_W-1:0] : in.sum[FIVE_W-1:0];
        prod         = {{RECIP_W{1'b0}}, sum_mag} * {{FIVE_W{1'b0}}, RECIP_5};
        out_next.hit  = in.hit;
        out_next.neg  = in.sum[SUM_W-1];
        out_next.qmag = prod[RECIP_SHIFT +: QMAG_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

`default_nettype wire

>>> hdl/sstv_vis_header_detector_top.sv
// Top level of the SSTV VIS header detector: configuration, pipeline and result register.
//
// One frequency sample per request, one result per sample. The block takes a sample in
// every cycle while results are taken; the result of a sample passes through the delay
// line, the tone tests, the bit decisions and divide by five, and the result register.
// The whole pipeline advances together, so s_ready falls only while a result waits
// unaccepted on m_valid. The delay line holds SAMPLES_PER_BIT * 22 samples and
// clears to zero on reset; those zeros count as real samples. Configuration writes are
// taken at any time and are meant for moments with no sample in flight.
`default_nettype none

module sstv_vis_header_detector_top #(
    parameter int unsigned SAMPLES_PER_BIT = svhd_pkg::SAMPLES_PER_BIT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [svhd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [svhd_pkg::FREQ_W-1:0]          cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [svhd_pkg::FREQ_W-1:0]          s_freq_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_header_found,
    output logic [svhd_pkg::CODE_W-1:0]          m_vis_code,
    output logic                                 m_parity_bit,
    output logic                                 m_ones_odd,
    output logic signed [svhd_pkg::SHIFT_W-1:0]  m_freq_shift
);
    import svhd_pkg::*;

    logic [MARGIN_W-1:0]     margin_reg;
    logic [FREQ_W-1:0]       leader_reg;
    logic [FREQ_W-1:0]       bit_tone_reg;
    logic signed [GAP_W-1:0] gap_reg;
    logic [FIVE_W-1:0]       five_leader_reg;
    logic [FIVE_W-1:0]       five_bit_reg;

    logic    adv;
    logic    line_valid_reg;
    taps_t   taps;
    logic    match_valid;
    match_t  match_q;
    logic    decide_valid;
    decide_t decide_q;

    logic                      m_valid_reg;
    logic                      found_reg;
    logic [CODE_W-1:0]         code_reg;
    logic                      parity_reg;
    logic                      odd_reg;
    logic signed [SHIFT_W-1:0] shift_reg;
    logic signed [SHIFT_W-1:0] shift_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg   <= FREQ_MARGIN_RST;
            leader_reg   <= LEADER_TONE_RST;
            bit_tone_reg <= BIT_TONE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FREQ_MARGIN: margin_reg   <= cfg_wdata[MARGIN_W-1:0];
                REG_LEADER_TONE: leader_reg   <= cfg_wdata;
                REG_BIT_TONE:    bit_tone_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        gap_reg         <= $signed({1'b0, leader_reg}) - $signed({1'b0, bit_tone_reg});
        five_leader_reg <= {1'b0, leader_reg, 2'b00} + {3'b000, leader_reg};
        five_bit_reg    <= {1'b0, bit_tone_reg, 2'b00} + {3'b000, bit_tone_reg};
    end

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_valid_reg <= 1'b0;
        end else if (adv) begin
            line_valid_reg <= s_valid;
        end
    end

    svhd_delay_line #(
        .SAMPLES_PER_BIT(SAMPLES_PER_BIT)
    ) u_line (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s_valid && adv),
        .din      (s_freq_sample),
        .taps     (taps)
    );

    svhd_match u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (line_valid_reg),
        .taps        (taps),
        .margin      (margin_reg),
        .gap         (gap_reg),
        .five_leader (five_leader_reg),
        .out_valid   (match_valid),
        .out         (match_q)
    );

    svhd_decide u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (match_valid),
        .in        (match_q),
        .five_bit  (five_bit_reg),
        .out_valid (decide_valid),
        .out       (decide_q)
    );

    // saturate on the magnitude, then apply the sign
    always_comb begin
        if (!decide_q.hit) begin
            shift_next = '0;
        end else if (decide_q.neg) begin
            if (decide_q.qmag > SHIFT_NEG_LIMIT) begin
                shift_next = -$signed(SHIFT_NEG_LIMIT[SHIFT_W-1:0]);
            end else begin
                shift_next = -$signed(decide_q.qmag[SHIFT_W-1:0]);
            end
        end else begin
            if (decide_q.qmag > SHIFT_POS_LIMIT) begin
                shift_next = $signed(SHIFT_POS_LIMIT[SHIFT_W-1:0]);
            end else begin
                shift_next = $signed(decide_q.qmag[SHIFT_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= decide_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            found_reg  <= decide_q.hit;
            code_reg   <= decide_q.word[CODE_W-1:0];
            parity_reg <= decide_q.word[VIS_BITS-1];
            odd_reg    <= ^decide_q.word;
            shift_reg  <= shift_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_header_found = found_reg;
    assign m_vis_code     = code_reg;
    assign m_parity_bit   = parity_reg;
    assign m_ones_odd     = odd_reg;
    assign m_freq_shift   = shift_reg;

endmodule

`default_nettype wire

>>> hdl/svhd_checker.sv
// Port-level checks of the VIS header detector and their binding to the top level.
`default_nettype none

module svhd_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_ready,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic                                 m_header_found,
    input  logic [svhd_pkg::CODE_W-1:0]          m_vis_code,
    input  logic                                 m_parity_bit,
    input  logic                                 m_ones_odd,
    input  logic signed [svhd_pkg::SHIFT_W-1:0]  m_freq_shift
);
    import svhd_pkg::*;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request taken while result stalled");

    a_miss_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_header_found) |->
            (m_vis_code == '0 && !m_parity_bit && !m_ones_odd && m_freq_shift == '0))
        else $error("non-zero fields without a header");

    a_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ones_odd == ^{m_parity_bit, m_vis_code}))
        else $error("ones count parity mismatch");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_header_found) && $stable(m_vis_code)
             && $stable(m_parity_bit) && $stable(m_ones_odd) && $stable(m_freq_shift)))
        else $error("stalled result changed");

endmodule

bind sstv_vis_header_detector_top svhd_checker u_svhd_checker (.*);

`default_nettype wire

>>> test/vis_header_checker.sv
// Checker for the SSTV VIS header detector: tracks the delay line, predicts each result and compares.
module vis_header_checker import svhd_pkg::*; #(
    parameter int unsigned SAMPLES_PER_BIT = SAMPLES_PER_BIT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [FREQ_W-1:0]          cfg_wdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [FREQ_W-1:0]          s_freq_sample,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_header_found,
    input  logic [CODE_W-1:0]          m_vis_code,
    input  logic                       m_parity_bit,
    input  logic                       m_ones_odd,
    input  logic signed [SHIFT_W-1:0]  m_freq_shift,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_LEN = SAMPLES_PER_BIT * FRAME_BITS;
    localparam longint SHIFT_HI = 16383;
    localparam longint SHIFT_LO = -16384;

    typedef struct packed {
        logic                      found;
        logic [CODE_W-1:0]         code;
        logic                      par;
        logic                      odd;
        logic signed [SHIFT_W-1:0] shift;
    } vis_result_t;

    logic [FREQ_W-1:0]   tone_line [LINE_LEN];
    int unsigned         line_pos;
    logic [MARGIN_W-1:0] margin_r;
    logic [FREQ_W-1:0]   leader_r;
    logic [FREQ_W-1:0]   bittone_r;
    vis_result_t         vis_results_due [$];

    // age 0 is the oldest sample, LINE_LEN-1 the newest
    function automatic longint tone_at(int unsigned age);
        return longint'(tone_line[(line_pos + 1 + age) % LINE_LEN]);
    endfunction

    function automatic bit under_margin(longint v);
        return ((v < 0) ? -v : v) < longint'(margin_r);
    endfunction

    function automatic vis_result_t decode_vis_header(logic [FREQ_W-1:0] tone_in);
        vis_result_t r;
        longint f0;
        longint gap;
        longint s;
        longint q;
        logic [VIS_BITS-1:0] word;
        int ones;
        r = '0;
        word = '0;
        ones = 0;
        tone_line[line_pos] = tone_in;
        gap = longint'(leader_r) - longint'(bittone_r);
        f0 = tone_at(0);
        if (under_margin(tone_at(LEADER_TAP_A * SAMPLES_PER_BIT) - f0)
                && under_margin(tone_at(LEADER_TAP_B * SAMPLES_PER_BIT) - f0)
                && under_margin(tone_at(LEADER_TAP_C * SAMPLES_PER_BIT) - f0)
                && under_margin(tone_at(LEADER_TAP_D * SAMPLES_PER_BIT) - f0)
                && under_margin(tone_at(START_TAP * SAMPLES_PER_BIT) - f0 + gap)
                && under_margin(tone_at(STOP_TAP * SAMPLES_PER_BIT) - f0 + gap)) begin
            s = f0 + tone_at(LEADER_TAP_A * SAMPLES_PER_BIT)
                   + tone_at(LEADER_TAP_B * SAMPLES_PER_BIT)
                   + tone_at(LEADER_TAP_C * SAMPLES_PER_BIT)
                   + tone_at(LEADER_TAP_D * SAMPLES_PER_BIT)
                   - 5 * longint'(leader_r);
            q = s / 5;
            // decide bits on the exact offset, before saturation
            for (int k = 0; k < VIS_BITS; k++) begin
                if (5 * tone_at((FIRST_DATA_TAP + k) * SAMPLES_PER_BIT) - s
                        < 5 * longint'(bittone_r)) begin
                    word[k] = 1'b1;
                    ones++;
                end
            end
            if (q > SHIFT_HI) q = SHIFT_HI;
            if (q < SHIFT_LO) q = SHIFT_LO;
            r.found = 1'b1;
            r.code  = word[CODE_W-1:0];
            r.par   = word[VIS_BITS-1];
            r.odd   = ones[0];
            r.shift = SHIFT_W'(q);
        end
        line_pos = (line_pos + 1) % LINE_LEN;
        return r;
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        vis_result_t want;
        if (!aresetn) begin
            foreach (tone_line[i]) tone_line[i] = '0;
            line_pos = 0;
            margin_r = FREQ_MARGIN_RST;
            leader_r = LEADER_TONE_RST;
            bittone_r = BIT_TONE_RST;
            vis_results_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FREQ_MARGIN: margin_r = cfg_wdata[MARGIN_W-1:0];
                    REG_LEADER_TONE: leader_r = cfg_wdata;
                    REG_BIT_TONE:    bittone_r = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                vis_results_due.push_back(decode_vis_header(s_freq_sample));
            if (m_valid && m_ready) begin
                if (vis_results_due.size() == 0) begin
                    $display("%0t ns: result with none due, expected nothing, actual found=%0d",
                             $time, m_header_found);
                    fail_count++;
                end else begin
                    want = vis_results_due.pop_front();
                    check_field("header_found", want.found, m_header_found);
                    check_field("vis_code", want.code, m_vis_code);
                    check_field("parity_bit", want.par, m_parity_bit);
                    check_field("ones_odd", want.odd, m_ones_odd);
                    check_field("freq_shift", longint'(want.shift), longint'(m_freq_shift));
                end
            end
        end
        pending = vis_results_due.size();
    end

endmodule

>>> test/tb_sstv_vis_header_detector_top.sv
// Testbench top for the SSTV VIS header detector: clock, reset, stimulus and verdict.
module tb_sstv_vis_header_detector_top;
    timeunit 1ns;
    timeprecision 1ps;
    import svhd_pkg::*;

    localparam int unsigned SPB = SAMPLES_PER_BIT_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LINGER = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [FREQ_W-1:0]          cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic [FREQ_W-1:0]          s_freq_sample;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_header_found;
    logic [CODE_W-1:0]          m_vis_code;
    logic                       m_parity_bit;
    logic                       m_ones_odd;
    logic signed [SHIFT_W-1:0]  m_freq_shift;
    int                         fail_count;
    int                         pending;

    bit idle_en;
    int samples_sent;
    int cur_margin;
    int cur_leader;
    int cur_tone;

    sstv_vis_header_detector_top #(.SAMPLES_PER_BIT(SPB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_freq_sample(s_freq_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_header_found(m_header_found), .m_vis_code(m_vis_code),
        .m_parity_bit(m_parity_bit), .m_ones_odd(m_ones_odd), .m_freq_shift(m_freq_shift)
    );

    vis_header_checker #(.SAMPLES_PER_BIT(SPB)) vis_check (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_freq_sample(s_freq_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_header_found(m_header_found), .m_vis_code(m_vis_code),
        .m_parity_bit(m_parity_bit), .m_ones_odd(m_ones_odd), .m_freq_shift(m_freq_shift),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [FREQ_W-1:0] clamp_tone(longint v);
        if (v < 0) return '0;
        if (v > 65535) return '1;
        return FREQ_W'(v);
    endfunction

    function automatic longint edge_jitter();
        longint j;
        case ($urandom_range(0, 7))
            0: j = cur_margin - 1;
            1: j = cur_margin;
            default: j = longint'($urandom_range(0, cur_margin / 2));
        endcase
        return $urandom_range(0, 1) ? j : -j;
    endfunction

    function automatic longint pick_offset();
        longint big;
        big = longint'($urandom_range(15000, 25000));
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? big : -big;
        return longint'($urandom_range(0, 1200)) - 600;
    endfunction

    task automatic push_sample(input longint v);
        if (idle_en && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_freq_sample <= clamp_tone(v);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        samples_sent++;
    endtask

    // hold requests until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_config(input int margin, input int leader, input int tone);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FREQ_MARGIN;
        cfg_wdata <= {4'($urandom), 12'(margin)};
        @(negedge aclk);
        cfg_index <= REG_LEADER_TONE;
        cfg_wdata <= 16'(leader);
        @(negedge aclk);
        cfg_index <= REG_BIT_TONE;
        cfg_wdata <= 16'(tone);
        @(negedge aclk);
        cfg_index <= REG_UNMAPPED;
        cfg_wdata <= 16'($urandom);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        cur_margin = margin;
        cur_leader = leader;
        cur_tone = tone;
    endtask

    // leader, start bit, eight data bits, stop bit; spoil replaces one period with a stray tone
    task automatic send_vis_frame(input longint off, input logic [VIS_BITS-1:0] word,
                                  input int periods, input int spoil);
        longint base;
        longint spread;
        for (int p = 0; p < periods; p++) begin
            if (p < START_TAP) begin
                base = cur_leader + off;
            end else if (p == START_TAP || p == STOP_TAP) begin
                base = cur_tone + off;
            end else begin
                spread = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 2)) : 1600;
                base = word[p - FIRST_DATA_TAP] ? cur_tone + off - spread
                                                : cur_tone + off + spread;
            end
            if (p == spoil) base = longint'($urandom_range(0, 65535));
            push_sample((p == 0) ? base : base + edge_jitter());
            for (int j = 1; j < SPB; j++)
                push_sample(base + longint'($urandom_range(0, 60)) - 30);
        end
    endtask

    task automatic send_flat_run();
        longint tone;
        int len;
        case ($urandom_range(0, 3))
            0: tone = 0;
            1: tone = 65535;
            2: tone = cur_leader;
            default: tone = longint'($urandom_range(0, 65535));
        endcase
        len = $urandom_range(0, 1) ? $urandom_range(1, 20)
                                   : $urandom_range(SPB * FRAME_BITS, SPB * FRAME_BITS + 30);
        repeat (len) push_sample(tone);
    endtask

    task automatic run_phase(input int margin, input int leader, input int tone,
                             input int quota, input bit idling);
        int stop_at;
        load_config(margin, leader, tone);
        stop_at = samples_sent + quota;
        while (samples_sent < stop_at) begin
            idle_en = idling && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_vis_frame(pick_offset(), VIS_BITS'($urandom), FRAME_BITS, -1);
                6: send_vis_frame(pick_offset(), VIS_BITS'($urandom),
                                  $urandom_range(1, FRAME_BITS), $urandom_range(0, FRAME_BITS - 1));
                7: send_flat_run();
                default: repeat ($urandom_range(1, 20)) push_sample($urandom_range(0, 65535));
            endcase
        end
    endtask

    initial begin
        int unsigned directed_tones [10];
        directed_tones = '{0, 65535, 0, 1, 16'h8000, 16'h7fff, 16'h5555, 16'haaaa,
                           19200, 30400};
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_freq_sample = '0;
        idle_en = 1'b0;
        samples_sent = 0;
        cur_margin = FREQ_MARGIN_RST;
        cur_leader = LEADER_TONE_RST;
        cur_tone = BIT_TONE_RST;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // equal tones let the zeroed history match at once
        load_config(400, 19200, 19200);
        foreach (directed_tones[i]) push_sample(directed_tones[i]);
        load_config(0, 30400, 19200);
        push_sample(0);
        push_sample(30400);
        push_sample(19200);
        push_sample(65535);

        run_phase(FREQ_MARGIN_RST, LEADER_TONE_RST, BIT_TONE_RST, 230, 1'b1);
        run_phase(4095, 0, 0, 150, 1'b1);
        run_phase(4095, 65535, 65535, 150, 1'b1);
        run_phase($urandom_range(1, 4095), $urandom_range(0, 65535), $urandom_range(0, 65535),
                  180, 1'b1);
        run_phase(1, $urandom_range(0, 65535), $urandom_range(0, 65535), 150, 1'b1);
        run_phase(0, LEADER_TONE_RST, BIT_TONE_RST, 80, 1'b1);
        run_phase(FREQ_MARGIN_RST, LEADER_TONE_RST, BIT_TONE_RST, 210, 1'b0);

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (LINGER) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (idle_en && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t ns: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
